// File: hdl/scl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_pkg
// shared types and constants of the servo command line parser
// ----------------------------------------------------------------------------
package scl_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned ValW   = 16;
	localparam int unsigned ProdW  = 2 * ValW;
	localparam int unsigned CfgIdxW = 1;

	localparam logic [ByteW-1:0] AsciiNewline = 8'd10;
	localparam logic [ByteW-1:0] AsciiSpace   = 8'd32;
	localparam logic [ByteW-1:0] AsciiZero    = 8'd48;
	localparam logic [ByteW-1:0] AsciiNine    = 8'd57;

	localparam logic [ValW-1:0] ValMax = 16'hFFFF;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] RegPulseBase = 1'b0;
	localparam logic [CfgIdxW-1:0] RegPulseSpan = 1'b1;

	localparam logic [ValW-1:0] PulseBaseReset = 16'd2000;
	localparam logic [ValW-1:0] PulseSpanReset = 16'd2000;

	// p / 180 = (p / 4) / 45; products at or above 180 * 2^16 always saturate
	localparam logic [ProdW-1:0] SatLimit = 32'd11796480;
	localparam int unsigned QuarterW = 22;
	localparam int unsigned RecipW   = 23;
	localparam int unsigned RecipSh  = 28;
	localparam logic [RecipW-1:0] Recip45 = 23'd5965233;
	localparam int unsigned RecProdW = QuarterW + RecipW;

	typedef struct packed {
		logic [ValW-1:0] x_deg;
		logic [ValW-1:0] y_deg;
	} scl_line_t;

endpackage

// File: hdl/servo_command_line_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_command_line_parser_top
// parses "Y X" newline-terminated ascii lines into two servo compare values
// ----------------------------------------------------------------------------
// channel  | dir | handshake               | payload
// s_*      | in  | s_tvalid / s_tready     | rx_byte
// m_*      | out | m_tvalid / m_tready     | x_compare, y_compare, x_degrees, y_degrees
// cfg_*    | in  | cfg_we                  | index 0 pulse_base, 1 pulse_span
//
// one byte beat per cycle while s_tready is high; a newline beat reaches m_tvalid
// through line register, multiply, reciprocal divide, add and saturate
// reset clears line state and loads 2000 into pulse_base and pulse_span
// a stalled output holds each stage only once the stage after it is full
// ----------------------------------------------------------------------------
module servo_command_line_parser_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [scl_pkg::ByteW-1:0]    s_tdata,   // [7:0] rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [15:0] x_compare, [31:16] y_compare, [47:32] x_degrees, [63:48] y_degrees
	output logic [4*scl_pkg::ValW-1:0]   m_tdata,
	input  logic                         cfg_we,
	input  logic [scl_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [scl_pkg::ValW-1:0]     cfg_data
);

	logic [scl_pkg::ValW-1:0]  pulse_base_q;
	logic [scl_pkg::ValW-1:0]  pulse_span_q;
	logic                      line_valid_s1;
	scl_pkg::scl_line_t        line_s1;
	logic                      line_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_base_q <= scl_pkg::PulseBaseReset;
			pulse_span_q <= scl_pkg::PulseSpanReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scl_pkg::RegPulseBase: pulse_base_q <= cfg_data;
				scl_pkg::RegPulseSpan: pulse_span_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = line_ready;

	scl_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (s_tvalid && s_tready),
		.rx_byte       (s_tdata),
		.line_ready    (line_ready),
		.line_valid_s1 (line_valid_s1),
		.line_s1       (line_s1)
	);

	scl_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.pulse_base    (pulse_base_q),
		.pulse_span    (pulse_span_q),
		.line_valid_s1 (line_valid_s1),
		.line_s1       (line_s1),
		.line_ready    (line_ready),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

endmodule

// File: hdl/scl_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_parser
// byte-wise line parser: digit accumulators, field switch, line register
// ----------------------------------------------------------------------------
module scl_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [scl_pkg::ByteW-1:0]  rx_byte,
	input  logic                       line_ready,
	output logic                       line_valid_s1,
	output scl_pkg::scl_line_t         line_s1
);

	logic                      second_q;
	logic [scl_pkg::ValW-1:0]  y_acc_q;
	logic [scl_pkg::ValW-1:0]  x_acc_q;
	logic [scl_pkg::ValW-1:0]  y_lat_q;

	logic                      is_nl;
	logic                      is_space;
	logic                      is_digit;
	logic [3:0]                digit;
	logic [scl_pkg::ValW-1:0]  acc_sel;
	logic [scl_pkg::ValW+3:0]  acc_next;
	logic [scl_pkg::ValW-1:0]  acc_sat;

	assign is_nl    = (rx_byte == scl_pkg::AsciiNewline);
	assign is_space = (rx_byte == scl_pkg::AsciiSpace);
	assign is_digit = (rx_byte >= scl_pkg::AsciiZero) && (rx_byte <= scl_pkg::AsciiNine);
	assign digit    = 4'(rx_byte - scl_pkg::AsciiZero);

	// acc * 10 + digit as shifts and adds, then clamp to 16 bits
	always_comb begin
		acc_sel  = second_q ? x_acc_q : y_acc_q;
		acc_next = ({4'd0, acc_sel} << 3) + ({4'd0, acc_sel} << 1)
			+ {(scl_pkg::ValW)'(0), digit};
		acc_sat  = (acc_next > {4'd0, scl_pkg::ValMax}) ? scl_pkg::ValMax
			: acc_next[scl_pkg::ValW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
			y_acc_q  <= '0;
			x_acc_q  <= '0;
			y_lat_q  <= '0;
		end else if (accept) begin
			priority if (is_nl) begin
				second_q <= 1'b0;
				y_acc_q  <= '0;
				x_acc_q  <= '0;
				y_lat_q  <= '0;
			end else if (is_space) begin
				y_lat_q  <= y_acc_q;
				second_q <= 1'b1;
			end else if (is_digit) begin
				if (second_q) begin
					x_acc_q <= acc_sat;
				end else begin
					y_acc_q <= acc_sat;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_s1 <= 1'b0;
		end else if (line_ready) begin
			line_valid_s1 <= accept && is_nl;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_nl) begin
			line_s1.x_deg <= x_acc_q;
			line_s1.y_deg <= y_lat_q;
		end
	end

	a_clear_after_nl: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept && is_nl) |-> (!second_q && y_acc_q == '0 && x_acc_q == '0
			&& y_lat_q == '0))
		else $error("line state not cleared after newline");

	a_space_sets_field: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept && is_space) |-> (second_q && y_lat_q == $past(y_acc_q)))
		else $error("space did not latch y and switch field");

endmodule

// File: hdl/scl_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_scale
// angle to compare value: multiply, divide by 180, add base, saturate
// ----------------------------------------------------------------------------
module scl_scale (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [scl_pkg::ValW-1:0]    pulse_base,
	input  logic [scl_pkg::ValW-1:0]    pulse_span,
	input  logic                        line_valid_s1,
	input  scl_pkg::scl_line_t          line_s1,
	output logic                        line_ready,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [4*scl_pkg::ValW-1:0]  m_tdata
);

	logic                        v_s2;
	logic                        v_s3;
	scl_pkg::scl_line_t          line_s2;
	scl_pkg::scl_line_t          line_s3;
	logic [scl_pkg::ProdW-1:0]   xp_s2;
	logic [scl_pkg::ProdW-1:0]   yp_s2;
	logic [scl_pkg::ValW-1:0]    xq_s3;
	logic [scl_pkg::ValW-1:0]    yq_s3;
	logic                        xbig_s3;
	logic                        ybig_s3;

	logic                        rdy_out;
	logic                        rdy3;
	logic                        rdy2;
	logic [scl_pkg::RecProdW-1:0] xr;
	logic [scl_pkg::RecProdW-1:0] yr;
	logic [scl_pkg::ValW:0]      xsum;
	logic [scl_pkg::ValW:0]      ysum;
	logic [scl_pkg::ValW-1:0]    xcmp;
	logic [scl_pkg::ValW-1:0]    ycmp;

	assign rdy_out    = !m_tvalid || m_tready;
	assign rdy3       = !v_s3 || rdy_out;
	assign rdy2       = !v_s2 || rdy3;
	assign line_ready = !line_valid_s1 || rdy2;

	// quotient by 45 through a reciprocal, exact for the quarter product range
	assign xr = {(scl_pkg::RecipW)'(0), xp_s2[scl_pkg::QuarterW+1:2]}
		* {(scl_pkg::QuarterW)'(0), scl_pkg::Recip45};
	assign yr = {(scl_pkg::RecipW)'(0), yp_s2[scl_pkg::QuarterW+1:2]}
		* {(scl_pkg::QuarterW)'(0), scl_pkg::Recip45};

	assign xsum = {1'b0, pulse_base} + {1'b0, xq_s3};
	assign ysum = {1'b0, pulse_base} + {1'b0, yq_s3};
	assign xcmp = (xbig_s3 || xsum[scl_pkg::ValW]) ? scl_pkg::ValMax : xsum[scl_pkg::ValW-1:0];
	assign ycmp = (ybig_s3 || ysum[scl_pkg::ValW]) ? scl_pkg::ValMax : ysum[scl_pkg::ValW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (rdy2) begin
				v_s2 <= line_valid_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				m_tvalid <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && line_valid_s1) begin
			line_s2 <= line_s1;
			xp_s2   <= {(scl_pkg::ValW)'(0), pulse_span} * {(scl_pkg::ValW)'(0), line_s1.x_deg};
			yp_s2   <= {(scl_pkg::ValW)'(0), pulse_span} * {(scl_pkg::ValW)'(0), line_s1.y_deg};
		end
		if (rdy3 && v_s2) begin
			line_s3 <= line_s2;
			xbig_s3 <= (xp_s2 >= scl_pkg::SatLimit);
			ybig_s3 <= (yp_s2 >= scl_pkg::SatLimit);
			xq_s3   <= xr[scl_pkg::RecipSh +: scl_pkg::ValW];
			yq_s3   <= yr[scl_pkg::RecipSh +: scl_pkg::ValW];
		end
		if (rdy_out && v_s3) begin
			m_tdata <= {line_s3.y_deg, line_s3.x_deg, ycmp, xcmp};
		end
	end

	a_result_advances: assert property (@(posedge clk) disable iff (!arst_n)
		$past(v_s3 && rdy_out) |-> m_tvalid)
		else $error("finished line lost before output register");

endmodule
